// ===== rtl/core/esa_pkg.sv =====
package esa_pkg;

  localparam int MAX_LEN_DEF    = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int POS_W          = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_TAKE_A,
    ST_CMP,
    ST_WB,
    ST_OUT_RD,
    ST_OUT_SEND
  } esa_state_t;

  typedef struct packed {
    logic load;       // store the accepted input word
    logic start;      // outer index to zero
    logic rd_i;       // read entry i
    logic take_a;     // latch entry i, read i+1
    logic cmp;        // compare/swap entry j, read j+1
    logic wb;         // write back entry i, advance i
    logic out_start;  // output index to zero
    logic out_rd;     // read entry k
    logic out_next;   // advance k
    logic clear;      // list done
  } esa_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic k_last;
  } esa_stat_t;

endpackage

// ===== rtl/core/esa_if.sv =====
interface esa_in_if import esa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      final_item;

  modport source (output valid, value, final_item, input ready);
  modport sink (input valid, value, final_item, output ready);
endinterface

interface esa_out_if import esa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic        [POS_W-1:0]   position;
  logic                      final_result;
  logic                      overflow;

  modport source (output valid, sorted_value, position, final_result, overflow, input ready);
  modport sink (input valid, sorted_value, position, final_result, overflow, output ready);
endinterface

// ===== rtl/core/esa_ctrl.sv =====
module esa_ctrl
  import esa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      in_final,
  input  logic      out_fire,
  input  esa_stat_t stat,
  output esa_cmd_t  cmd,
  output logic      in_ready,
  output logic      out_valid
);

  esa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_final) state_nxt = ST_SORT_I;
      end
      ST_SORT_I: begin
        state_nxt = stat.i_last ? ST_OUT_RD : ST_TAKE_A;
      end
      ST_TAKE_A: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.j_last) state_nxt = ST_WB;
      end
      ST_WB: begin
        state_nxt = ST_SORT_I;
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        if (out_fire) state_nxt = stat.k_last ? ST_LOAD : ST_OUT_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.load  = in_fire;
        cmd.start = in_fire && in_final;
      end
      ST_SORT_I: begin
        cmd.rd_i      = !stat.i_last;
        cmd.out_start = stat.i_last;
      end
      ST_TAKE_A: begin
        cmd.take_a = 1'b1;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
      end
      ST_OUT_SEND: begin
        out_valid    = 1'b1;
        cmd.out_next = out_fire && !stat.k_last;
        cmd.clear    = out_fire && stat.k_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/esa_dp.sv =====
module esa_dp
  import esa_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  esa_cmd_t                  cmd,
  input  logic signed [VALUE_W-1:0] in_value,
  output esa_stat_t                 stat,
  output logic signed [VALUE_W-1:0] out_sorted_value,
  output logic        [POS_W-1:0]   out_position,
  output logic                      out_overflow
);

  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic signed [DATA_WIDTH-1:0] mem_r [MAX_LEN];
  logic signed [DATA_WIDTH-1:0] rd_r;
  logic signed [DATA_WIDTH-1:0] a_r, a_nxt;
  logic        [CNT_W-1:0]      count_r, count_nxt;
  logic                         dropped_r, dropped_nxt;
  logic        [CNT_W-1:0]      i_r, i_nxt;
  logic        [CNT_W-1:0]      j_r, j_nxt;
  logic        [CNT_W-1:0]      k_r, k_nxt;

  logic [CNT_W-1:0]             i_inc, j_inc, k_inc;
  logic                         room;
  logic                         greater;
  logic                         we;
  logic [ADDR_W-1:0]            wa;
  logic signed [DATA_WIDTH-1:0] wd;
  logic                         re;
  logic [ADDR_W-1:0]            ra;

  assign i_inc   = i_r + CNT_W'(1);
  assign j_inc   = j_r + CNT_W'(1);
  assign k_inc   = k_r + CNT_W'(1);
  assign room    = count_r < CNT_W'(MAX_LEN);
  assign greater = a_r > rd_r;

  assign stat.i_last = i_inc >= count_r;
  assign stat.j_last = j_inc >= count_r;
  assign stat.k_last = k_inc >= count_r;

  always_comb begin
    we = 1'b0;
    wa = count_r[ADDR_W-1:0];
    wd = DATA_WIDTH'(in_value);
    if (cmd.load && room) begin
      we = 1'b1;
    end else if (cmd.cmp && greater) begin
      we = 1'b1;
      wa = j_r[ADDR_W-1:0];
      wd = a_r;
    end else if (cmd.wb) begin
      we = 1'b1;
      wa = i_r[ADDR_W-1:0];
      wd = a_r;
    end
  end

  always_comb begin
    re = cmd.rd_i | cmd.take_a | cmd.cmp | cmd.out_rd;
    ra = i_r[ADDR_W-1:0];
    if (cmd.take_a) begin
      ra = i_inc[ADDR_W-1:0];
    end else if (cmd.cmp) begin
      ra = j_inc[ADDR_W-1:0];
    end else if (cmd.out_rd) begin
      ra = k_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    if (re) rd_r <= mem_r[ra];
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    a_nxt       = a_r;
    if (cmd.load) begin
      if (room) count_nxt = count_r + CNT_W'(1);
      else      dropped_nxt = 1'b1;
    end
    if (cmd.start)  i_nxt = '0;
    if (cmd.take_a) begin
      a_nxt = rd_r;
      j_nxt = i_inc;
    end
    if (cmd.cmp) begin
      if (greater) a_nxt = rd_r;
      j_nxt = j_inc;
    end
    if (cmd.wb)        i_nxt = i_inc;
    if (cmd.out_start) k_nxt = '0;
    if (cmd.out_next)  k_nxt = k_inc;
    if (cmd.clear) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  assign out_sorted_value = VALUE_W'(rd_r);
  assign out_position     = POS_W'(k_r);
  assign out_overflow     = dropped_r;

endmodule

// ===== rtl/core/exchange_sort_ascending_top.sv =====
// Collects a list of signed words (one per input word, the last one flagged by
// final_item) into a buffer of MAX_LEN entries with one read and one write
// port, sorts it ascending and sends it back one word per element with its
// position, a last flag and an overflow flag (set on every word of a list that
// lost elements to a full buffer). No result is given until the final word.
// The sort steps one compare per cycle through the buffer's read and write
// ports, n(n-1)/2 compares for a list of n words; each output word is then
// read and held until taken.
// No input is taken from the final word until the last result has been taken.
module exchange_sort_ascending_top
  import esa_pkg::*;
#(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  esa_in_if.sink   in_ch,
  esa_out_if.source out_ch
);

  esa_cmd_t  cmd;
  esa_stat_t stat;
  logic      in_fire;
  logic      out_fire;
  logic      in_ready;
  logic      out_valid;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid && out_ch.ready;

  esa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_final  (in_ch.final_item),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  esa_dp #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_ch.value),
    .stat             (stat),
    .out_sorted_value (out_ch.sorted_value),
    .out_position     (out_ch.position),
    .out_overflow     (out_ch.overflow)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.final_result = stat.k_last;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_final_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.final_item |=> !in_ready)
    else $error("input still open after final word");

  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.final_result |=> in_ready && !out_valid)
    else $error("block not back to loading after last result");

  a_position_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_ch.final_result |=> ##1
      out_valid && out_ch.position == $past(out_ch.position, 2) + POS_W'(1))
    else $error("result position did not advance by one");
`endif

endmodule

// ===== tb/sv/exchange_sort_ascending_top_tb.sv =====
module exchange_sort_ascending_top_tb;
  import esa_pkg::*;

  localparam int LIST_MAX    = MAX_LEN_DEF;
  localparam int ELEM_W      = DATA_WIDTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 150;
  localparam int WORD_TARGET = 480;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      final_item;
  } list_word_t;

  typedef struct {
    logic signed [VALUE_W-1:0] sorted_value;
    logic [POS_W-1:0]          position;
    logic                      final_result;
    logic                      overflow;
  } sorted_word_t;

  logic clk;
  logic rst_n;

  esa_in_if  in_ch ();
  esa_out_if out_ch ();

  exchange_sort_ascending_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_word_t   word_q[$];
  sorted_word_t sorted_q[$];

  logic signed [VALUE_W-1:0] list_buf[LIST_MAX];
  int  list_len;
  bit  list_dropped;

  int  fail_cnt;
  int  checked_cnt;
  int  lists_done;
  int  overflow_lists;
  int  full_lists;
  int  words_in;
  int  stored_words;
  int  total_words;
  int  hold_left;
  bit  hold_done;
  int  cycle;
  int  quiet;

  wire calm = (cycle >= 1500) && (cycle < 3000);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [VALUE_W-1:0] fit_width(input logic signed [VALUE_W-1:0] v);
    logic signed [VALUE_W-1:0] r;
    int sh;
    sh = (ELEM_W < VALUE_W) ? VALUE_W - ELEM_W : 0;
    r = v <<< sh;
    r = r >>> sh;
    return r;
  endfunction

  task automatic sort_into_results();
    logic signed [VALUE_W-1:0] t;
    sorted_word_t w;
    for (int i = 0; i < list_len; i++) begin
      for (int j = i + 1; j < list_len; j++) begin
        if (list_buf[i] > list_buf[j]) begin
          t = list_buf[i];
          list_buf[i] = list_buf[j];
          list_buf[j] = t;
        end
      end
    end
    for (int k = 0; k < list_len; k++) begin
      w.sorted_value = list_buf[k];
      w.position     = POS_W'(k);
      w.final_result = (k + 1 == list_len);
      w.overflow     = list_dropped;
      sorted_q.push_back(w);
    end
    lists_done++;
    if (list_dropped) overflow_lists++;
    if (list_len == LIST_MAX) full_lists++;
    list_len     = 0;
    list_dropped = 1'b0;
  endtask

  task automatic take_word(input logic signed [VALUE_W-1:0] v, input logic fin);
    words_in++;
    if (list_len < LIST_MAX) begin
      list_buf[list_len] = fit_width(v);
      list_len++;
    end else begin
      list_dropped = 1'b1;
    end
    if (fin) sort_into_results();
  endtask

  task automatic check_word();
    sorted_word_t w;
    if (sorted_q.size() == 0) begin
      $error("unexpected result: sorted_value %0d position %0d",
             out_ch.sorted_value, out_ch.position);
      fail_cnt++;
    end else begin
      w = sorted_q.pop_front();
      checked_cnt++;
      if (out_ch.sorted_value !== w.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", w.sorted_value, out_ch.sorted_value);
        fail_cnt++;
      end
      if (out_ch.position !== w.position) begin
        $error("position: expected %0d, got %0d", w.position, out_ch.position);
        fail_cnt++;
      end
      if (out_ch.final_result !== w.final_result) begin
        $error("final_result: expected %0b, got %0b", w.final_result, out_ch.final_result);
        fail_cnt++;
      end
      if (out_ch.overflow !== w.overflow) begin
        $error("overflow: expected %0b, got %0b", w.overflow, out_ch.overflow);
        fail_cnt++;
      end
    end
  endtask

  task automatic push_word(input logic signed [VALUE_W-1:0] v, input logic fin);
    list_word_t w;
    w.value      = v;
    w.final_item = fin;
    word_q.push_back(w);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input int style);
    logic signed [VALUE_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(8)) - 4;
      default: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sh0;
          default: v = -32'sd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    list_word_t w;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.value      <= '0;
      in_ch.final_item <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (word_q.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
        w = word_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.value      <= w.value;
        in_ch.final_item <= w.final_item;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) take_word(in_ch.value, in_ch.final_item);
      if (out_ch.valid && out_ch.ready) check_word();
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && checked_cnt >= HOLD_AFTER && out_ch.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int len;
    int r;
    int style;
    rst_n            = 1'b0;
    stored_words     = 0;

    // single word lists at both extremes
    push_word(32'sh8000_0000, 1'b1);
    push_word(32'sh7FFF_FFFF, 1'b1);
    // extremes mixed with duplicates
    push_word(32'sh7FFF_FFFF, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh0, 1'b0);
    push_word(-32'sd1, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh7FFF_FFFF, 1'b1);
    // all equal
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b0);
    push_word(32'sd5, 1'b1);
    // descending
    for (int i = 3; i >= -2; i--) push_word(i, i == -2);
    // already ascending
    for (int i = -1; i <= 1; i++) push_word(i, i == 1);
    stored_words = 20;

    while (stored_words < WORD_TARGET) begin
      r = $urandom_range(99);
      if (r < 60) len = $urandom_range(8, 1);
      else if (r < 80) len = $urandom_range(31, 9);
      else if (r < 90) len = LIST_MAX;
      else len = $urandom_range(LIST_MAX + 8, LIST_MAX + 1);
      r = $urandom_range(99);
      style = (r < 70) ? 0 : (r < 90) ? 1 : 2;
      for (int i = 0; i < len; i++) begin
        push_word(pick_value(($urandom_range(9) == 0) ? 2 : style), i == len - 1);
      end
      stored_words += (len < LIST_MAX) ? len : LIST_MAX;
    end
    total_words = word_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (words_in < total_words || sorted_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sorted %0d lists from %0d input words: %0d full, %0d with dropped words.",
             lists_done, words_in, full_lists, overflow_lists);
    $display("Checked %0d sorted words, output held off for %0d cycles once.",
             checked_cnt, HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/esa_pkg.sv
rtl/core/esa_if.sv
rtl/core/esa_ctrl.sv
rtl/core/esa_dp.sv
rtl/core/exchange_sort_ascending_top.sv
tb/sv/exchange_sort_ascending_top_tb.sv
